// File: rtl/pd_steering_wheel_mixer_assert.svh
// Assertion macros used by the checker of the steering mixer.
`ifndef PD_STEERING_WHEEL_MIXER_ASSERT_SVH
`define PD_STEERING_WHEEL_MIXER_ASSERT_SVH

// Same-cycle implication, masked while reset is held.
`define PDSW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// Next-cycle implication, masked while reset is held.
`define PDSW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

// Next-cycle implication that is also checked through reset.
`define PDSW_ASSERT_RESET(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed: reset check");

`endif

// File: rtl/pdsw_pkg.sv
`timescale 1ns / 1ps

package pdsw_pkg;

    // Field widths.
    localparam int ErrW    = 8;
    localparam int GainW   = 8;
    localparam int SpeedW  = 8;
    localparam int CtrlW   = 18;
    localparam int ModeW   = 2;
    localparam int CfgIdxW = 2;
    localparam int CfgDatW = 8;

    // Register indexes on the configuration port.
    localparam logic [CfgIdxW-1:0] CFG_PROP_GAIN  = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_DERIV_GAIN = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_MAX_SPEED  = 2'd2;

    // Register values after reset.
    localparam logic [GainW-1:0]  RST_PROP_GAIN  = 8'd150;
    localparam logic [GainW-1:0]  RST_DERIV_GAIN = 8'd5;
    localparam logic [SpeedW-1:0] RST_MAX_SPEED  = 8'd100;

    // Wheel mode codes.
    typedef enum logic [ModeW-1:0] {
        MODE_FORWARD    = 2'd0,
        MODE_SPIN_LEFT  = 2'd1,
        MODE_SPIN_RIGHT = 2'd2
    } t_mode;

    typedef logic signed [CtrlW-1:0] t_ctrl;

    // Current register settings, seen by both halves.
    typedef struct packed {
        logic [GainW-1:0]  prop_gain;
        logic [GainW-1:0]  deriv_gain;
        logic [SpeedW-1:0] max_speed;
    } t_cfg;

    // One queue entry together with its valid flag.
    typedef struct packed {
        logic  valid;
        t_ctrl control_value;
    } t_entry;

endpackage

// File: rtl/pdsw_err_if.sv
`timescale 1ns / 1ps

interface pdsw_err_if;
    logic                               valid;
    logic                               ready;
    logic signed [pdsw_pkg::ErrW-1:0]   error_sample;

    modport source (output valid, output error_sample, input ready);
    modport sink   (input valid, input error_sample, output ready);
endinterface

// File: rtl/pdsw_res_if.sv
`timescale 1ns / 1ps

interface pdsw_res_if;
    logic                               valid;
    logic                               ready;
    logic [pdsw_pkg::ModeW-1:0]         wheel_mode;
    logic [pdsw_pkg::SpeedW-1:0]        left_speed;
    logic [pdsw_pkg::SpeedW-1:0]        right_speed;
    logic signed [pdsw_pkg::CtrlW-1:0]  control_value;

    modport source (output valid, output wheel_mode, output left_speed,
                    output right_speed, output control_value, input ready);
    modport sink   (input valid, input wheel_mode, input left_speed,
                    input right_speed, input control_value, output ready);
endinterface

// File: rtl/pdsw_cfg_if.sv
`timescale 1ns / 1ps

interface pdsw_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [pdsw_pkg::CfgIdxW-1:0]   index;
    logic [pdsw_pkg::CfgDatW-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/pd_steering_wheel_mixer.sv
`timescale 1ns / 1ps

// PD steering controller with a differential-drive wheel mixer. Each error
// sample gives one result: control = prop_gain*error + deriv_gain*(error -
// previous error), plus the wheel mode and the left and right speeds taken
// from it. The front half forms the PD sum in the cycle of the sample
// transfer and writes it to a short queue; the back half maps it to wheel
// commands and writes them into an output register. A sample can be taken in
// every cycle while the queue has room; a result passes through the queue and
// then the output register. When the output stalls, the queue absorbs up to
// QUEUE_DEPTH sums before the input side stalls too. The configuration
// port is ready whenever reset is released; its registers should only be
// changed while no result is pending.
module pd_steering_wheel_mixer #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    pdsw_err_if.sink        i_err,
    pdsw_res_if.source      o_res,
    pdsw_cfg_if.sink        i_cfg
);

    pdsw_pkg::t_cfg     r_cfg;
    pdsw_pkg::t_cfg     n_cfg;
    pdsw_pkg::t_entry   w_push;
    pdsw_pkg::t_entry   w_head;
    logic               w_q_full;
    logic               w_pop;

    // Configuration register writes.
    assign i_cfg.ready = i_rst_n;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            case (i_cfg.index)
                pdsw_pkg::CFG_PROP_GAIN:  n_cfg.prop_gain  = i_cfg.data;
                pdsw_pkg::CFG_DERIV_GAIN: n_cfg.deriv_gain = i_cfg.data;
                pdsw_pkg::CFG_MAX_SPEED:  n_cfg.max_speed  = i_cfg.data;
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain  <= pdsw_pkg::RST_PROP_GAIN;
            r_cfg.deriv_gain <= pdsw_pkg::RST_DERIV_GAIN;
            r_cfg.max_speed  <= pdsw_pkg::RST_MAX_SPEED;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Front: sample transfer and PD sum.
    pdsw_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_err.valid),
        .i_error_sample (i_err.error_sample),
        .o_ready        (i_err.ready),
        .i_cfg          (r_cfg),
        .i_q_full       (w_q_full),
        .o_push         (w_push)
    );

    // Queue between the halves.
    pdsw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_full  (w_q_full),
        .o_head  (w_head),
        .i_pop   (w_pop)
    );

    // Back: wheel mixer and output register.
    pdsw_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (w_head),
        .o_pop           (w_pop),
        .i_max_speed     (r_cfg.max_speed),
        .o_valid         (o_res.valid),
        .i_ready         (o_res.ready),
        .o_wheel_mode    (o_res.wheel_mode),
        .o_left_speed    (o_res.left_speed),
        .o_right_speed   (o_res.right_speed),
        .o_control_value (o_res.control_value)
    );

endmodule

// File: rtl/pdsw_front.sv
`timescale 1ns / 1ps

module pdsw_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  logic signed [pdsw_pkg::ErrW-1:0]   i_error_sample,
    output logic                               o_ready,
    input  pdsw_pkg::t_cfg                     i_cfg,
    input  logic                               i_q_full,
    output pdsw_pkg::t_entry                   o_push
);

    logic signed [pdsw_pkg::ErrW-1:0]   r_last_error;
    logic signed [pdsw_pkg::ErrW-1:0]   n_last_error;
    logic signed [pdsw_pkg::ErrW:0]     w_diff;
    logic signed [2*pdsw_pkg::ErrW:0]   w_prop;
    logic signed [pdsw_pkg::CtrlW-1:0]  w_deriv;
    logic                               w_accept;

    // A sample transfer can happen whenever reset is released and the queue has room.
    assign o_ready  = i_rst_n && !i_q_full;
    assign w_accept = i_valid && o_ready;

    // PD sum: both products side by side, then one add.
    always_comb begin
        w_diff  = (pdsw_pkg::ErrW+1)'(i_error_sample) - (pdsw_pkg::ErrW+1)'(r_last_error);
        w_prop  = (2*pdsw_pkg::ErrW+1)'($signed({1'b0, i_cfg.prop_gain}))
                * (2*pdsw_pkg::ErrW+1)'(i_error_sample);
        w_deriv = pdsw_pkg::CtrlW'($signed({1'b0, i_cfg.deriv_gain}))
                * pdsw_pkg::CtrlW'(w_diff);
        o_push.valid         = w_accept;
        o_push.control_value = pdsw_pkg::CtrlW'(w_prop) + w_deriv;
    end

    // The previous error moves on with every accepted sample.
    always_comb begin
        n_last_error = r_last_error;
        if (w_accept) begin
            n_last_error = i_error_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_error <= '0;
        end else begin
            r_last_error <= n_last_error;
        end
    end

endmodule

// File: rtl/pdsw_queue.sv
`timescale 1ns / 1ps

module pdsw_queue #(
    parameter int DEPTH = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pdsw_pkg::t_entry  i_push,
    output logic              o_full,
    output pdsw_pkg::t_entry  o_head,
    input  logic              i_pop
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    pdsw_pkg::t_ctrl    r_slot [DEPTH];
    logic [AW-1:0]      r_wr_ptr;
    logic [AW-1:0]      n_wr_ptr;
    logic [AW-1:0]      r_rd_ptr;
    logic [AW-1:0]      n_rd_ptr;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    logic               w_push;
    logic               w_pop;

    assign o_full               = (r_count == CW'(DEPTH));
    assign o_head.valid         = (r_count != '0);
    assign o_head.control_value = r_slot[r_rd_ptr];
    assign w_push               = i_push.valid && !o_full;
    assign w_pop                = i_pop && o_head.valid;

    // Pointer and fill count bookkeeping.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
        end
        if (w_push && !w_pop) begin
            n_count = r_count + CW'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= i_push.control_value;
        end
    end

endmodule

// File: rtl/pdsw_back.sv
`timescale 1ns / 1ps

module pdsw_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  pdsw_pkg::t_entry                   i_head,
    output logic                               o_pop,
    input  logic [pdsw_pkg::SpeedW-1:0]        i_max_speed,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [pdsw_pkg::ModeW-1:0]         o_wheel_mode,
    output logic [pdsw_pkg::SpeedW-1:0]        o_left_speed,
    output logic [pdsw_pkg::SpeedW-1:0]        o_right_speed,
    output logic signed [pdsw_pkg::CtrlW-1:0]  o_control_value
);

    localparam int MagW = pdsw_pkg::CtrlW - 1;

    logic                              r_valid;
    logic                              n_valid;
    pdsw_pkg::t_mode                   r_mode;
    pdsw_pkg::t_mode                   n_mode;
    logic [pdsw_pkg::SpeedW-1:0]       r_left;
    logic [pdsw_pkg::SpeedW-1:0]       n_left;
    logic [pdsw_pkg::SpeedW-1:0]       r_right;
    logic [pdsw_pkg::SpeedW-1:0]       n_right;
    pdsw_pkg::t_ctrl                   r_ctrl;
    logic [MagW-1:0]                   w_mag;
    logic [MagW-1:0]                   w_m;
    logic [MagW-1:0]                   w_m2;
    logic                              w_neg;
    logic [pdsw_pkg::SpeedW-1:0]       w_slow;
    logic [pdsw_pkg::SpeedW-1:0]       w_spin;

    // Take the queue head whenever the output register is free or drains.
    assign o_pop = i_head.valid && (!r_valid || i_ready);

    // Magnitude and the two region bounds.
    always_comb begin
        w_neg  = i_head.control_value[pdsw_pkg::CtrlW-1];
        w_mag  = w_neg ? MagW'(-i_head.control_value) : MagW'(i_head.control_value);
        w_m    = MagW'(i_max_speed);
        w_m2   = MagW'({i_max_speed, 1'b0});
        w_slow = pdsw_pkg::SpeedW'(w_m - w_mag);
        w_spin = pdsw_pkg::SpeedW'(w_mag - w_m);
    end

    // Wheel mixer: pick the region, then the slowed side.
    always_comb begin
        n_mode  = pdsw_pkg::MODE_FORWARD;
        n_left  = i_max_speed;
        n_right = i_max_speed;
        if (w_mag == '0) begin
            n_mode = pdsw_pkg::MODE_FORWARD;
        end else if (w_mag < w_m) begin
            n_mode = pdsw_pkg::MODE_FORWARD;
            if (w_neg) begin
                n_right = w_slow;
            end else begin
                n_left = w_slow;
            end
        end else if (w_mag > w_m && w_mag < w_m2) begin
            if (w_neg) begin
                n_mode  = pdsw_pkg::MODE_SPIN_RIGHT;
                n_right = w_spin;
            end else begin
                n_mode = pdsw_pkg::MODE_SPIN_LEFT;
                n_left = w_spin;
            end
        end else begin
            n_mode = w_neg ? pdsw_pkg::MODE_SPIN_RIGHT : pdsw_pkg::MODE_SPIN_LEFT;
        end
    end

    // Output register valid flag.
    always_comb begin
        n_valid = r_valid;
        if (o_pop) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_mode  <= n_mode;
            r_left  <= n_left;
            r_right <= n_right;
            r_ctrl  <= i_head.control_value;
        end
    end

    assign o_valid         = r_valid;
    assign o_wheel_mode    = r_mode;
    assign o_left_speed    = r_left;
    assign o_right_speed   = r_right;
    assign o_control_value = r_ctrl;

endmodule

// File: rtl/pdsw_checker.sv
`timescale 1ns / 1ps
`include "pd_steering_wheel_mixer_assert.svh"

module pdsw_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_ready,
    input  logic                               i_out_valid,
    input  logic                               i_out_ready,
    input  logic [pdsw_pkg::ModeW-1:0]         i_wheel_mode,
    input  logic [pdsw_pkg::SpeedW-1:0]        i_left_speed,
    input  logic [pdsw_pkg::SpeedW-1:0]        i_right_speed,
    input  logic signed [pdsw_pkg::CtrlW-1:0]  i_control_value
);

    // No result is offered in the cycle after reset.
    `PDSW_ASSERT_RESET(a_idle_after_reset, i_clk, !i_rst_n, !i_out_valid)

    // A stalled result stays offered.
    `PDSW_ASSERT_NEXT(a_hold_valid, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)

    // A left spin only follows a positive sum.
    `PDSW_ASSERT_NOW(a_spin_left_sign, i_clk, i_rst_n, i_out_valid && i_wheel_mode == pdsw_pkg::MODE_SPIN_LEFT, !i_control_value[pdsw_pkg::CtrlW-1] && i_control_value != '0)

    // A zero sum drives straight with equal wheels.
    `PDSW_ASSERT_NOW(a_zero_straight, i_clk, i_rst_n, i_out_valid && i_control_value == '0, i_wheel_mode == pdsw_pkg::MODE_FORWARD && i_left_speed == i_right_speed)

    // The configuration port never pushes back.
    `PDSW_ASSERT_NOW(a_cfg_ready, i_clk, i_rst_n, 1'b1, i_cfg_ready)

endmodule

bind pd_steering_wheel_mixer pdsw_checker u_pdsw_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_cfg_ready     (i_cfg.ready),
    .i_out_valid     (o_res.valid),
    .i_out_ready     (o_res.ready),
    .i_wheel_mode    (o_res.wheel_mode),
    .i_left_speed    (o_res.left_speed),
    .i_right_speed   (o_res.right_speed),
    .i_control_value (o_res.control_value)
);
